/* rtl/hwt_pkg.sv */
package hwt_pkg;

  localparam int BLK       = 8;
  localparam int BLK_AREA  = BLK * BLK;
  localparam int SAMPLE_W  = 19;
  localparam int PART_W    = 23;
  localparam int ACC_W     = 26;
  localparam int VALUE_W   = 22;
  localparam int SHIFT     = 3;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_COL,
    ST_ROW
  } hwt_state_t;

  // configuration register indexes
  localparam logic REG_DIRECTION = 1'b0;
  localparam logic REG_CLAMP     = 1'b1;

  localparam logic signed [1:0] CP = 2'sb01;
  localparam logic signed [1:0] CM = 2'sb11;
  localparam logic signed [1:0] CZ = 2'sb00;

  // unnormalised 8-point haar matrix
  localparam logic signed [1:0] HAAR [BLK][BLK] = '{
    '{CP, CP, CP, CP, CP, CP, CP, CP},
    '{CP, CP, CP, CP, CM, CM, CM, CM},
    '{CP, CP, CM, CM, CZ, CZ, CZ, CZ},
    '{CZ, CZ, CZ, CZ, CP, CP, CM, CM},
    '{CP, CM, CZ, CZ, CZ, CZ, CZ, CZ},
    '{CZ, CZ, CP, CM, CZ, CZ, CZ, CZ},
    '{CZ, CZ, CZ, CZ, CP, CM, CZ, CZ},
    '{CZ, CZ, CZ, CZ, CZ, CZ, CP, CM}
  };

  localparam logic signed [PART_W-1:0] CLAMP_LO = -23'sd32768;
  localparam logic signed [PART_W-1:0] CLAMP_HI = 23'sd32767;

  // partial store write port
  typedef struct packed {
    logic                     en;
    logic [5:0]               addr;
    logic signed [PART_W-1:0] data;
  } hwt_pw_t;

  // value times matrix entry, transposed in inverse mode
  function automatic logic signed [ACC_W-1:0] coef_term(
    input logic                    inv,
    input logic [2:0]              r,
    input logic [2:0]              c,
    input logic signed [ACC_W-1:0] v
  );
    logic signed [1:0] cf;
    cf = inv ? HAAR[c][r] : HAAR[r][c];
    case (cf)
      CP:      coef_term = v;
      CM:      coef_term = -v;
      default: coef_term = '0;
    endcase
  endfunction

endpackage

/* rtl/hwt_col.sv */
module hwt_col (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load_en,
  input  logic [5:0]                           load_addr,
  input  logic signed [hwt_pkg::SAMPLE_W-1:0]  load_data,
  input  logic                                 start,
  input  logic                                 inverse,
  output hwt_pkg::hwt_pw_t                     pw
);
  import hwt_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [BLK_AREA];
  logic signed [SAMPLE_W-1:0] rd_data;

  logic       issuing;
  logic [5:0] rd_t;
  logic       rv;
  logic [2:0] rk;
  logic [2:0] rj;
  logic       wbusy;
  logic [2:0] wcnt;
  logic [2:0] wcol;
  logic       capture;

  logic signed [PART_W-1:0] acc      [BLK];
  logic signed [PART_W-1:0] acc_next [BLK];
  logic signed [PART_W-1:0] hold     [BLK];
  logic signed [ACC_W-1:0]  rd_ext;

  // sample store, read column-wise: address k*8+j
  always_ff @(posedge clk) begin
    if (load_en) begin
      mem[load_addr] <= load_data;
    end
    if (issuing) begin
      rd_data <= mem[{rd_t[2:0], rd_t[5:3]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      rd_t    <= '0;
      rv      <= 1'b0;
      wbusy   <= 1'b0;
      wcnt    <= '0;
    end else begin
      if (start) begin
        issuing <= 1'b1;
        rd_t    <= '0;
      end else if (issuing) begin
        rd_t <= rd_t + 6'd1;
        if (rd_t == 6'd63) begin
          issuing <= 1'b0;
        end
      end
      rv <= issuing;
      // a new column lands as the last write of the previous one goes out
      if (capture) begin
        wbusy <= 1'b1;
        wcnt  <= '0;
      end else if (wbusy) begin
        wcnt <= wcnt + 3'd1;
        if (wcnt == 3'd7) begin
          wbusy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rk <= rd_t[2:0];
    rj <= rd_t[5:3];
    if (capture) begin
      wcol <= rj;
      hold <= acc_next;
    end
    if (rv) begin
      acc <= acc_next;
    end
  end

  assign capture = rv && (rk == 3'd7);
  assign rd_ext  = {{(ACC_W-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};

  always_comb begin
    logic signed [ACC_W-1:0] term;
    for (int i = 0; i < BLK; i++) begin
      term        = coef_term(inverse, 3'(i), rk, rd_ext);
      acc_next[i] = ((rk == 3'd0) ? '0 : acc[i]) + $signed(term[PART_W-1:0]);
    end
  end

  assign pw.en   = wbusy;
  assign pw.addr = {wcnt, wcol};
  assign pw.data = hold[wcnt];

endmodule

/* rtl/hwt_row.sv */
module hwt_row (
  input  logic                                clk,
  input  logic                                rst,
  input  hwt_pkg::hwt_pw_t                    pw,
  input  logic                                start,
  input  logic                                inverse,
  input  logic                                clamp,
  output logic                                done,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [hwt_pkg::VALUE_W-1:0]  value_out,
  output logic [5:0]                          position,
  output logic                                block_last
);
  import hwt_pkg::*;

  logic signed [PART_W-1:0] mem [BLK_AREA];
  logic signed [PART_W-1:0] rd_data;

  logic       issuing;
  logic       rwait;
  logic       issue;
  logic [2:0] rrow;
  logic [2:0] rk;
  logic       rv;
  logic [2:0] rvk;
  logic [2:0] rvrow;
  logic       acc_full;
  logic [2:0] acc_row;
  logic       xfer;
  logic       bank_busy;
  logic [2:0] bank_row;
  logic [2:0] ecnt;

  logic signed [ACC_W-1:0]   acc  [BLK];
  logic signed [VALUE_W-1:0] res  [BLK];
  logic signed [VALUE_W-1:0] bank [BLK];
  logic signed [ACC_W-1:0]   rd_ext;

  // partial store, read row-wise: address i*8+k
  always_ff @(posedge clk) begin
    if (pw.en) begin
      mem[pw.addr] <= pw.data;
    end
    if (issue) begin
      rd_data <= mem[{rrow, rk}];
    end
  end

  assign issue = issuing && !rwait;
  assign xfer  = acc_full && !bank_busy;
  assign done  = xfer && (acc_row == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing   <= 1'b0;
      rwait     <= 1'b0;
      rrow      <= '0;
      rk        <= '0;
      rv        <= 1'b0;
      acc_full  <= 1'b0;
      bank_busy <= 1'b0;
      ecnt      <= '0;
    end else begin
      if (start) begin
        issuing <= 1'b1;
        rwait   <= 1'b0;
        rrow    <= '0;
        rk      <= '0;
      end else begin
        if (issue) begin
          rk <= rk + 3'd1;
          // hold off the next row until this one has left the accumulators
          if (rk == 3'd7) begin
            rwait <= 1'b1;
            rrow  <= rrow + 3'd1;
            if (rrow == 3'd7) begin
              issuing <= 1'b0;
            end
          end
        end
        if (xfer) begin
          rwait <= 1'b0;
        end
      end
      rv <= issue;
      if (rv && (rvk == 3'd7)) begin
        acc_full <= 1'b1;
      end else if (xfer) begin
        acc_full <= 1'b0;
      end
      if (xfer) begin
        bank_busy <= 1'b1;
        ecnt      <= '0;
      end else if (bank_busy && out_ready) begin
        ecnt <= ecnt + 3'd1;
        if (ecnt == 3'd7) begin
          bank_busy <= 1'b0;
        end
      end
    end
  end

  assign rd_ext = {{(ACC_W-PART_W){rd_data[PART_W-1]}}, rd_data};

  always_ff @(posedge clk) begin
    rvk   <= rk;
    rvrow <= rrow;
    if (rv) begin
      for (int j = 0; j < BLK; j++) begin
        acc[j] <= ((rvk == 3'd0) ? '0 : acc[j]) + coef_term(inverse, 3'(j), rvk, rd_ext);
      end
      if (rvk == 3'd7) begin
        acc_row <= rvrow;
      end
    end
    if (xfer) begin
      bank     <= res;
      bank_row <= acc_row;
    end
  end

  // arithmetic shift by three, then optional saturation
  always_comb begin
    logic signed [PART_W-1:0] sh;
    logic signed [PART_W-1:0] sat;
    for (int j = 0; j < BLK; j++) begin
      sh  = acc[j][ACC_W-1:SHIFT];
      sat = sh;
      if (clamp && (sh < CLAMP_LO)) begin
        sat = CLAMP_LO;
      end else if (clamp && (sh > CLAMP_HI)) begin
        sat = CLAMP_HI;
      end
      res[j] = sat[VALUE_W-1:0];
    end
  end

  assign out_valid  = bank_busy;
  assign value_out  = bank[ecnt];
  assign position   = {bank_row, ecnt};
  assign block_last = (bank_row == 3'd7) && (ecnt == 3'd7);

endmodule

/* rtl/haar_8x8_forward_inverse_transform.sv */
// 8x8 two-dimensional integer haar transform, forward (C*X*C^T)>>3 or inverse
// (C^T*Y*C)>>3 with an arithmetic shift, optional saturation to 16 bits. Load
// 64 samples in raster order, one item per cycle; the block then runs a column
// pass (64 single-port reads of the sample store, eight sums of one column
// accumulated in parallel, written back to the partial store under the next
// column's reads) and a row pass (eight reads of the partial store per row,
// the next row's reads held until the row has left the accumulators) whose 64
// results leave in raster order through an eight-entry output bank, the last
// marked by block_last. The single read port of each store limits the rate at
// which a block of 64 loads and 64 results passes through.
// in_ready is high only while loading; the final row of results may still be
// draining while the next block loads. direction and clamp_output are sampled
// with the 64th sample of a block.
module haar_8x8_forward_inverse_transform (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [hwt_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [hwt_pkg::VALUE_W-1:0]  value_out,
  output logic [5:0]                          position,
  output logic                                block_last,
  input  logic                                cfg_en,
  input  logic                                cfg_index,
  input  logic                                cfg_data
);
  import hwt_pkg::*;

  hwt_state_t state;
  hwt_state_t state_next;

  logic       direction;
  logic       clamp_output;
  logic       blk_inv;
  logic       blk_clamp;
  logic [5:0] load_count;
  logic       in_acc;
  logic       col_start;
  logic       row_start;
  logic       row_done;
  hwt_pw_t    pw;

  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction    <= 1'b0;
      clamp_output <= 1'b0;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_DIRECTION: direction    <= cfg_data;
        REG_CLAMP:     clamp_output <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        load_count <= load_count + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (col_start) begin
      blk_inv   <= direction;
      blk_clamp <= clamp_output;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    col_start  = 1'b0;
    row_start  = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid && (load_count == 6'd63)) begin
          col_start  = 1'b1;
          state_next = ST_COL;
        end
      end
      ST_COL: begin
        // last partial sum written
        if (pw.en && (pw.addr == 6'd63)) begin
          row_start  = 1'b1;
          state_next = ST_ROW;
        end
      end
      ST_ROW: begin
        if (row_done) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  hwt_col u_col (
    .clk       (clk),
    .rst       (rst),
    .load_en   (in_acc),
    .load_addr (load_count),
    .load_data (sample_in),
    .start     (col_start),
    .inverse   (blk_inv),
    .pw        (pw)
  );

  hwt_row u_row (
    .clk        (clk),
    .rst        (rst),
    .pw         (pw),
    .start      (row_start),
    .inverse    (blk_inv),
    .clamp      (blk_clamp),
    .done       (row_done),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value_out  (value_out),
    .position   (position),
    .block_last (block_last)
  );

endmodule

/* rtl/hwt_check.sv */
module hwt_check (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [hwt_pkg::VALUE_W-1:0]  value_out,
  input logic [5:0]                          position,
  input logic                                block_last
);

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && block_last |-> position == 6'd63)
    else $error("block_last away from the final position");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (position == 6'd63) |-> block_last)
    else $error("final position without block_last");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value_out) && $stable(position))
    else $error("result item changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item offered straight after reset");

endmodule

bind haar_8x8_forward_inverse_transform hwt_check u_hwt_check (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .value_out  (value_out),
  .position   (position),
  .block_last (block_last)
);
